@@ design/dtms_pkg.sv @@
// ----------------------------------------------------------------------------
// dtms_pkg
// Shared types and constants of the delimited text missing field statistics
// block: command and register codes, stream field widths, queue entry.
// ----------------------------------------------------------------------------
package dtms_pkg;

    localparam int CMD_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 6;
    localparam int VALUE_W     = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int NCOLS_W     = 7;
    localparam int EMPTY_W     = 7;
    localparam int MASK_W      = 64;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 40;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [EMPTY_W-1:0] EMPTY_MAX = '1;

    localparam logic KIND_EOL  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_DATA   = 3'd0,
        CMD_EOL    = 3'd1,
        CMD_RD_COL = 3'd2,
        CMD_RD_BIN = 3'd3,
        CMD_RD_TOT = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM   = 2'd0,
        CFG_NCOLS   = 2'd1,
        CFG_COLMASK = 2'd2,
        CFG_BINMASK = 2'd3
    } cfg_idx_t;

    // which counter a result word carries
    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_COL  = 2'd1,
        RD_BIN  = 2'd2,
        RD_TOT  = 2'd3
    } rd_sel_t;

    // one unit of work for the counter pipeline
    typedef struct packed {
        logic             col_inc;
        logic [IDX_W-1:0] col_addr;
        logic             bin_inc;
        logic [IDX_W-1:0] bin_addr;
        logic             tot_inc;
        logic             has_result;
        logic             result_kind;
        logic             line_bad;
        logic [IDX_W-1:0] hist_bin;
        rd_sel_t          rd_sel;
    } op_t;

endpackage

@@ design/dtms_ram.sv @@
// ----------------------------------------------------------------------------
// dtms_ram
// Simple dual port RAM, one write and one registered read port.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module dtms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/dtms_front.sv @@
// ----------------------------------------------------------------------------
// dtms_front
// Configuration registers and line parser. Classifies each accepted word,
// tracks the position within the line and the empty field count, and
// queues counter updates and result requests for the back end.
// ----------------------------------------------------------------------------
module dtms_front #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dtms_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [dtms_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                in_accept,
    input  logic [dtms_pkg::CMD_W-1:0]          in_command,
    input  logic [dtms_pkg::BYTE_W-1:0]         in_text_byte,
    input  logic [dtms_pkg::IDX_W-1:0]          in_read_index,
    output logic                                push,
    output dtms_pkg::op_t                       push_op
);

    localparam logic [dtms_pkg::NCOLS_W-1:0] MAX_COLS_V = dtms_pkg::NCOLS_W'(MAX_COLUMNS);

    logic [dtms_pkg::BYTE_W-1:0]  delim_reg;
    logic [dtms_pkg::NCOLS_W-1:0] ncols_reg;
    logic [dtms_pkg::MASK_W-1:0]  colmask_reg;
    logic [dtms_pkg::MASK_W-1:0]  binmask_reg;

    logic                          prev_delim_reg, prev_delim_next;
    logic [dtms_pkg::EMPTY_W-1:0]  empty_reg, empty_next;
    logic [dtms_pkg::NCOLS_W-1:0]  fpos_reg, fpos_next;

    logic [dtms_pkg::NCOLS_W-1:0]  eff_cols;
    logic                          is_delim;
    logic                          note;
    logic                          in_range;
    logic                          ignored;
    logic [dtms_pkg::EMPTY_W-1:0]  empty_after;
    logic                          bad_cnt;
    logic [dtms_pkg::NCOLS_W-1:0]  bin_full;
    logic [dtms_pkg::IDX_W-1:0]    bin;
    logic                          bad;
    logic                          idx_ok;
    dtms_pkg::cmd_t                cmd;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg   <= 8'd44;
            ncols_reg   <= 7'd64;
            colmask_reg <= '0;
            binmask_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (dtms_pkg::cfg_idx_t'(cfg_wr_index))
                dtms_pkg::CFG_DELIM:   delim_reg   <= cfg_wr_data[dtms_pkg::BYTE_W-1:0];
                dtms_pkg::CFG_NCOLS:   ncols_reg   <= cfg_wr_data[dtms_pkg::NCOLS_W-1:0];
                dtms_pkg::CFG_COLMASK: colmask_reg <= cfg_wr_data;
                dtms_pkg::CFG_BINMASK: binmask_reg <= cfg_wr_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_delim_reg <= 1'b1;
            empty_reg      <= '0;
            fpos_reg       <= '0;
        end else begin
            prev_delim_reg <= prev_delim_next;
            empty_reg      <= empty_next;
            fpos_reg       <= fpos_next;
        end
    end

    assign cmd      = dtms_pkg::cmd_t'(in_command);
    assign eff_cols = (ncols_reg > MAX_COLS_V) ? MAX_COLS_V : ncols_reg;
    assign is_delim = (in_text_byte == delim_reg);
    assign note     = prev_delim_reg &&
                      (((cmd == dtms_pkg::CMD_DATA) && is_delim) || (cmd == dtms_pkg::CMD_EOL));
    assign in_range = (fpos_reg < eff_cols);
    // an ignored column skips the line's empty count too
    assign ignored  = in_range && colmask_reg[fpos_reg[dtms_pkg::IDX_W-1:0]];

    assign empty_after = (note && !ignored && (empty_reg != dtms_pkg::EMPTY_MAX))
                         ? empty_reg + 7'd1 : empty_reg;

    assign bad_cnt  = (empty_after >= eff_cols);
    assign bin_full = eff_cols - 7'd1 - empty_after;
    assign bin      = bad_cnt ? '0 : bin_full[dtms_pkg::IDX_W-1:0];
    assign bad      = bad_cnt || binmask_reg[bin];
    assign idx_ok   = ({1'b0, in_read_index} < MAX_COLS_V);

    always_comb begin
        prev_delim_next = prev_delim_reg;
        empty_next      = empty_reg;
        fpos_next       = fpos_reg;
        push            = 1'b0;
        push_op         = '0;
        push_op.rd_sel  = dtms_pkg::RD_ZERO;

        if (in_accept) begin
            unique case (cmd)
                dtms_pkg::CMD_DATA: begin
                    prev_delim_next = is_delim;
                    empty_next      = empty_after;
                    if (is_delim && (fpos_reg < MAX_COLS_V)) begin
                        fpos_next = fpos_reg + 7'd1;
                    end
                    push             = note && in_range && !ignored;
                    push_op.col_inc  = 1'b1;
                    push_op.col_addr = fpos_reg[dtms_pkg::IDX_W-1:0];
                end
                dtms_pkg::CMD_EOL: begin
                    prev_delim_next     = 1'b1;
                    empty_next          = '0;
                    fpos_next           = '0;
                    push                = 1'b1;
                    push_op.col_inc     = note && in_range && !ignored;
                    push_op.col_addr    = fpos_reg[dtms_pkg::IDX_W-1:0];
                    push_op.bin_inc     = !bad;
                    push_op.bin_addr    = bin;
                    push_op.tot_inc     = 1'b1;
                    push_op.has_result  = 1'b1;
                    push_op.result_kind = dtms_pkg::KIND_EOL;
                    push_op.line_bad    = bad;
                    push_op.hist_bin    = bin;
                end
                dtms_pkg::CMD_RD_COL: begin
                    push                = 1'b1;
                    push_op.col_addr    = in_read_index;
                    push_op.has_result  = 1'b1;
                    push_op.result_kind = dtms_pkg::KIND_READ;
                    push_op.rd_sel      = idx_ok ? dtms_pkg::RD_COL : dtms_pkg::RD_ZERO;
                end
                dtms_pkg::CMD_RD_BIN: begin
                    push                = 1'b1;
                    push_op.bin_addr    = in_read_index;
                    push_op.has_result  = 1'b1;
                    push_op.result_kind = dtms_pkg::KIND_READ;
                    push_op.rd_sel      = idx_ok ? dtms_pkg::RD_BIN : dtms_pkg::RD_ZERO;
                end
                dtms_pkg::CMD_RD_TOT: begin
                    push                = 1'b1;
                    push_op.has_result  = 1'b1;
                    push_op.result_kind = dtms_pkg::KIND_READ;
                    push_op.rd_sel      = dtms_pkg::RD_TOT;
                end
                default: begin
                    // unused command codes are dropped
                    push = 1'b0;
                end
            endcase
        end
    end

endmodule

@@ design/dtms_queue.sv @@
// ----------------------------------------------------------------------------
// dtms_queue
// Short first-in first-out queue of work entries between the line parser
// and the counter pipeline.
// ----------------------------------------------------------------------------
module dtms_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  dtms_pkg::op_t push_op,
    output logic          full,
    input  logic          pop,
    output dtms_pkg::op_t pop_op,
    output logic          empty
);

    localparam logic [dtms_pkg::QPTR_W:0] DEPTH_V = (dtms_pkg::QPTR_W+1)'(dtms_pkg::QUEUE_DEPTH);

    dtms_pkg::op_t                 entry_reg [dtms_pkg::QUEUE_DEPTH];
    logic [dtms_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [dtms_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [dtms_pkg::QPTR_W:0]     count_reg, count_next;

    assign full   = (count_reg == DEPTH_V);
    assign empty  = (count_reg == '0);
    assign pop_op = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

@@ design/dtms_back.sv @@
// ----------------------------------------------------------------------------
// dtms_back
// Counter pipeline. Reads column and bin counters from RAM, applies
// saturating increments, and forms result words in the output register.
// ----------------------------------------------------------------------------
module dtms_back #(
    parameter int MAX_COLUMNS  = 64,
    parameter int COUNTER_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dtms_pkg::op_t                  q_op,
    input  logic                           q_empty,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dtms_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [0:0]                     m_tuser
);

    localparam int ADDR_W = $clog2(MAX_COLUMNS);

    // stage one
    logic                    s1_valid_reg, s1_valid_next;
    dtms_pkg::op_t           s1_op_reg;

    // value written in the cycle the stage one word was read
    logic                    fwd_col_valid_reg, fwd_bin_valid_reg;
    logic [ADDR_W-1:0]       fwd_col_addr_reg, fwd_bin_addr_reg;
    logic [COUNTER_BITS-1:0] fwd_col_data_reg, fwd_bin_data_reg;

    logic [MAX_COLUMNS-1:0]  col_vld_reg, bin_vld_reg;
    logic [COUNTER_BITS-1:0] total_reg;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_kind_reg;
    logic                    out_bad_reg;
    logic [dtms_pkg::IDX_W-1:0] out_bin_reg;
    logic [dtms_pkg::VALUE_W-1:0] out_value_reg;

    logic                    out_free;
    logic                    s1_adv;
    logic                    load_out;
    logic [ADDR_W-1:0]       col_addr, bin_addr;
    logic [COUNTER_BITS-1:0] col_rdata, bin_rdata;
    logic [COUNTER_BITS-1:0] col_old, bin_old, col_new, bin_new, total_new;
    logic                    col_we, bin_we, tot_we;
    logic [COUNTER_BITS-1:0] rd_value;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = !s1_valid_reg || !s1_op_reg.has_result || out_free;
    assign q_pop    = !q_empty && s1_adv;
    assign load_out = s1_valid_reg && s1_op_reg.has_result && s1_adv;

    assign col_addr = s1_op_reg.col_addr[ADDR_W-1:0];
    assign bin_addr = s1_op_reg.bin_addr[ADDR_W-1:0];

    assign col_we = s1_valid_reg && s1_adv && s1_op_reg.col_inc;
    assign bin_we = s1_valid_reg && s1_adv && s1_op_reg.bin_inc;
    assign tot_we = s1_valid_reg && s1_adv && s1_op_reg.tot_inc;

    dtms_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_col_ram (
        .aclk    (aclk),
        .wr_en   (col_we),
        .wr_addr (col_addr),
        .wr_data (col_new),
        .rd_en   (q_pop),
        .rd_addr (q_op.col_addr[ADDR_W-1:0]),
        .rd_data (col_rdata)
    );

    dtms_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_bin_ram (
        .aclk    (aclk),
        .wr_en   (bin_we),
        .wr_addr (bin_addr),
        .wr_data (bin_new),
        .rd_en   (q_pop),
        .rd_addr (q_op.bin_addr[ADDR_W-1:0]),
        .rd_data (bin_rdata)
    );

    // entries never written since reset read as zero
    always_comb begin
        if (fwd_col_valid_reg && (fwd_col_addr_reg == col_addr)) begin
            col_old = fwd_col_data_reg;
        end else if (col_vld_reg[col_addr]) begin
            col_old = col_rdata;
        end else begin
            col_old = '0;
        end
        if (fwd_bin_valid_reg && (fwd_bin_addr_reg == bin_addr)) begin
            bin_old = fwd_bin_data_reg;
        end else if (bin_vld_reg[bin_addr]) begin
            bin_old = bin_rdata;
        end else begin
            bin_old = '0;
        end
    end

    // saturating increments
    assign col_new   = (&col_old)   ? col_old   : col_old   + COUNTER_BITS'(1);
    assign bin_new   = (&bin_old)   ? bin_old   : bin_old   + COUNTER_BITS'(1);
    assign total_new = (&total_reg) ? total_reg : total_reg + COUNTER_BITS'(1);

    always_comb begin
        unique case (s1_op_reg.rd_sel)
            dtms_pkg::RD_ZERO: rd_value = '0;
            dtms_pkg::RD_COL:  rd_value = col_old;
            dtms_pkg::RD_BIN:  rd_value = bin_old;
            dtms_pkg::RD_TOT:  rd_value = total_reg;
        endcase
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (q_pop) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            fwd_col_valid_reg <= 1'b0;
            fwd_bin_valid_reg <= 1'b0;
            col_vld_reg       <= '0;
            bin_vld_reg       <= '0;
            total_reg         <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                fwd_col_valid_reg <= col_we;
                fwd_bin_valid_reg <= bin_we;
            end
            if (col_we) begin
                col_vld_reg[col_addr] <= 1'b1;
            end
            if (bin_we) begin
                bin_vld_reg[bin_addr] <= 1'b1;
            end
            if (tot_we) begin
                total_reg <= total_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_op_reg        <= q_op;
            fwd_col_addr_reg <= col_addr;
            fwd_col_data_reg <= col_new;
            fwd_bin_addr_reg <= bin_addr;
            fwd_bin_data_reg <= bin_new;
        end
        if (load_out) begin
            out_kind_reg  <= s1_op_reg.result_kind;
            out_bad_reg   <= s1_op_reg.line_bad;
            out_bin_reg   <= s1_op_reg.hist_bin;
            out_value_reg <= dtms_pkg::VALUE_W'(rd_value);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_value_reg, out_bin_reg, out_bad_reg};
    assign m_tuser  = out_kind_reg;

endmodule

@@ design/delimited_text_missing_field_stats_top.sv @@
// ----------------------------------------------------------------------------
// delimited_text_missing_field_stats_top
// Missing field statistics over delimited text: per column missing counts,
// a histogram of filled columns per line, and a line total, read back on
// command through the result stream.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                           tuser
//  s_        in   text_byte[7:0], read_index[13:8]              command[2:0]
//  m_        out  line_bad[0], histogram_bin[6:1],              result_kind[0]
//                 read_value[38:7]
//  cfg_wr_   in   write enable, register index, 64-bit data      -
//
//  One word per cycle sustained while the m_ side accepts results; a result
//  leaves through the work queue, counter RAM read and output register.
//  Counter RAMs are read and written back once per cycle with forwarding,
//  so back-to-back updates of one counter do not stall.
//  Reset is synchronous; counters read as zero through per-entry valid flags,
//  so no clearing pass is needed.
//  A stalled m_ side fills the four-entry work queue, then drops s_tready.
// ----------------------------------------------------------------------------
module delimited_text_missing_field_stats_top #(
    parameter int MAX_COLUMNS  = 64,
    parameter int COUNTER_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [dtms_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [dtms_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dtms_pkg::S_TDATA_W-1:0]    s_tdata,   // text_byte, read_index
    input  logic [dtms_pkg::CMD_W-1:0]        s_tuser,   // command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dtms_pkg::M_TDATA_W-1:0]    m_tdata,   // line_bad, histogram_bin, read_value
    output logic [0:0]                        m_tuser    // result_kind
);

    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    dtms_pkg::op_t push_op;
    dtms_pkg::op_t pop_op;

    assign s_tready = !q_full;

    dtms_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .in_accept     (s_tvalid && s_tready),
        .in_command    (s_tuser),
        .in_text_byte  (s_tdata[dtms_pkg::BYTE_W-1:0]),
        .in_read_index (s_tdata[dtms_pkg::BYTE_W +: dtms_pkg::IDX_W]),
        .push          (q_push),
        .push_op       (push_op)
    );

    dtms_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .pop_op  (pop_op),
        .empty   (q_empty)
    );

    dtms_back #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_op     (pop_op),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
